// ===== rtl/core/drfr_pkg.sv =====
// Package for the delimited response frame receiver.
// Holds frame delimiters, store sizes and the response record type.
// No dependencies.
package drfr_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int KEPT_BYTES   = 8;
  localparam int POS_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int KEPT_W       = $clog2(KEPT_BYTES);

  localparam logic [7:0] BYTE_START = 8'h7E;
  localparam logic [7:0] BYTE_END   = 8'hEF;

  typedef struct packed {
    logic [7:0]  version;
    logic [7:0]  length;
    logic [7:0]  command;
    logic [7:0]  feedback;
    logic [15:0] parameter_word;
  } resp_t;

endpackage

// ===== rtl/core/delimited_response_frame_receiver.sv =====
// Delimited response frame receiver: a transferred byte passes the input
// register, then the check into the result register. One byte per cycle
// unless stalled; the checksum is a six-byte add and compare.
// rst is synchronous: clears enable, open flag, position, store and valids.
// Uses drfr_pkg, drfr_in_stage, drfr_frame_store and drfr_out_stage.
module delimited_response_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  resp_version,
  output logic [7:0]  resp_length,
  output logic [7:0]  resp_command,
  output logic [7:0]  resp_feedback,
  output logic [15:0] resp_parameter
);

  logic            held_valid;
  logic [7:0]      held_byte;
  logic            slot_free;
  logic            take;
  logic            hit;
  drfr_pkg::resp_t resp_calc;
  drfr_pkg::resp_t resp_q;

  // Advance the held byte only when the result slot can take its outcome.
  assign take = held_valid && slot_free;

  drfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  drfr_frame_store u_store (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .process   (take),
    .cur_byte  (held_byte),
    .hit       (hit),
    .resp      (resp_calc)
  );

  drfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (hit),
    .resp_in   (resp_calc),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .resp_out  (resp_q)
  );

  assign resp_version   = resp_q.version;
  assign resp_length    = resp_q.length;
  assign resp_command   = resp_q.command;
  assign resp_feedback  = resp_q.feedback;
  assign resp_parameter = resp_q.parameter_word;

endmodule

// ===== rtl/core/drfr_in_stage.sv =====
// Input register of the frame receiver: holds one received byte.
// Depends on nothing but its ports.
module drfr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_q;
  logic [7:0] byte_q;

  // The stage can load when empty or when its byte leaves this cycle.
  assign in_stall   = valid_q && !take;
  assign held_valid = valid_q;
  assign held_byte  = byte_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!in_stall) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/drfr_frame_store.sv =====
// Frame state of the receiver: byte store, write position, open flag,
// enable register and the negated-sum check. Uses drfr_pkg.
module drfr_frame_store (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic           cfg_data,
  input  logic           process,
  input  logic [7:0]     cur_byte,
  output logic           hit,
  output drfr_pkg::resp_t resp
);

  logic [7:0]                 frame_bytes [drfr_pkg::KEPT_BYTES];
  logic [drfr_pkg::POS_W-1:0] write_position;
  logic                       frame_open;
  logic                       rx_enable;

  logic                       is_start;
  logic                       is_end;
  logic                       store_ok;
  logic [10:0]                sum;
  logic [15:0]                calc;
  logic [15:0]                sent;

  assign is_start = cur_byte == drfr_pkg::BYTE_START;
  assign is_end   = cur_byte == drfr_pkg::BYTE_END;
  assign store_ok = frame_open && !is_start && !is_end &&
                    (write_position < drfr_pkg::POS_W'(drfr_pkg::BUFFER_DEPTH));

  assign sum  = 11'(frame_bytes[0]) + 11'(frame_bytes[1]) + 11'(frame_bytes[2]) +
                11'(frame_bytes[3]) + 11'(frame_bytes[4]) + 11'(frame_bytes[5]);
  assign calc = 16'(0) - 16'(sum);
  assign sent = {frame_bytes[6], frame_bytes[7]};

  assign hit = process && rx_enable && is_end && (sent == calc);

  assign resp.version        = frame_bytes[0];
  assign resp.length         = frame_bytes[1];
  assign resp.command        = frame_bytes[2];
  assign resp.feedback       = frame_bytes[3];
  assign resp.parameter_word = {frame_bytes[4], frame_bytes[5]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable <= 1'b0;
    end else if (cfg_write) begin
      rx_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      frame_open     <= 1'b0;
    end else if (process && rx_enable) begin
      if (is_start) begin
        frame_open     <= 1'b1;
        write_position <= '0;
      end else if (is_end) begin
        frame_open <= 1'b0;
      end else if (store_ok) begin
        write_position <= write_position + drfr_pkg::POS_W'(1);
      end
    end
  end

  // Keep only the first eight positions; later bytes are counted up to sixteen and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < drfr_pkg::KEPT_BYTES; i++) begin
        frame_bytes[i] <= 8'h00;
      end
    end else if (process && rx_enable && store_ok &&
                 (write_position < drfr_pkg::POS_W'(drfr_pkg::KEPT_BYTES))) begin
      frame_bytes[write_position[drfr_pkg::KEPT_W-1:0]] <= cur_byte;
    end
  end

endmodule

// ===== rtl/core/drfr_out_stage.sv =====
// Result register of the frame receiver: holds one decoded response.
// Uses drfr_pkg for the response record.
module drfr_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  drfr_pkg::resp_t resp_in,
  output logic            slot_free,
  output logic            out_valid,
  input  logic            out_stall,
  output drfr_pkg::resp_t resp_out
);

  logic            valid_q;
  drfr_pkg::resp_t resp_q;

  assign slot_free = !valid_q || !out_stall;
  assign out_valid = valid_q;
  assign resp_out  = resp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      resp_q <= resp_in;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for delimited_response_frame_receiver.
// Drives serial bytes and the enable register, predicts responses and checks each transfer.
// Depends on drfr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ACTIVE_BYTES = 200;
  localparam int QUIET_BYTES  = 40;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES   = 6;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // One directed step: a byte transfer or an enable write (value[0]).
  typedef struct packed {
    row_kind_t       kind;
    logic [7:0]      value;
    logic            typed;
    logic            typed_hit;
    drfr_pkg::resp_t typed_resp;
  } step_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data  = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  resp_version;
  logic [7:0]  resp_length;
  logic [7:0]  resp_command;
  logic [7:0]  resp_feedback;
  logic [15:0] resp_parameter;

  // Receiver mirror
  logic [7:0]  kept [drfr_pkg::KEPT_BYTES];
  int unsigned wr_pos = 0;
  bit          open_q = 1'b0;
  bit          rx_on  = 1'b0;

  drfr_pkg::resp_t resp_q [$];
  int    fail_count  = 0;
  int    cycle_count = 0;
  int    quiet_left  = 0;
  int    run_left    = 0;
  bit    run_stall   = 1'b0;

  delimited_response_frame_receiver DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .resp_version   (resp_version),
    .resp_length    (resp_length),
    .resp_command   (resp_command),
    .resp_feedback  (resp_feedback),
    .resp_parameter (resp_parameter)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < drfr_pkg::KEPT_BYTES; i++) kept[i] = 8'h00;
  end

  // Advance the mirror by one byte; returns 1 when the byte closes a frame that checks out.
  function automatic bit take_byte(input logic [7:0] b, output drfr_pkg::resp_t r);
    logic [15:0] sum16;
    logic [15:0] sent;
    r = '0;
    if (!rx_on) return 1'b0;
    if (b == drfr_pkg::BYTE_START) begin
      open_q = 1'b1;
      wr_pos = 0;
      return 1'b0;
    end
    if (b == drfr_pkg::BYTE_END) begin
      // check whatever the store holds, open frame or not
      open_q = 1'b0;
      sum16 = 16'h0000;
      for (int i = 0; i < 6; i++) sum16 = sum16 + {8'h00, kept[i]};
      sent = {kept[6], kept[7]};
      if (sent != 16'h0000 - sum16) return 1'b0;
      r.version        = kept[0];
      r.length         = kept[1];
      r.command        = kept[2];
      r.feedback       = kept[3];
      r.parameter_word = {kept[4], kept[5]};
      return 1'b1;
    end
    if (open_q && wr_pos < drfr_pkg::BUFFER_DEPTH) begin
      if (wr_pos < drfr_pkg::KEPT_BYTES) kept[wr_pos] = b;
      wr_pos++;
    end
    return 1'b0;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [7:0] free_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == drfr_pkg::BYTE_START || v == drfr_pkg::BYTE_END);
    return v;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Present one byte after a random gap and hold it until the transfer.
  task automatic send_byte(input logic [7:0] v, output bit hit, output drfr_pkg::resp_t r);
    int gap;
    if (quiet_left > 0) begin
      gap = 0;
      quiet_left--;
    end else begin
      gap = pause_len();
      if ($urandom_range(0, 99) == 0) quiet_left = 60;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= v;
    do @(posedge clk); while (in_stall);
    hit = take_byte(v, r);
  endtask

  // Write the enable only once the receiver has gone quiet.
  task automatic set_enable(input bit v);
    in_valid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    rx_on = v;
  endtask

  // Response side: random stall runs, check every transfer against the oldest expectation.
  always @(posedge clk) begin
    drfr_pkg::resp_t want;
    drfr_pkg::resp_t got;
    got = '{resp_version, resp_length, resp_command, resp_feedback, resp_parameter};
    if (!rst && out_valid && !out_stall) begin
      if (resp_q.size() == 0) begin
        note_failure($sformatf("unexpected response: ver %h len %h cmd %h fb %h par %h",
                               got.version, got.length, got.command, got.feedback,
                               got.parameter_word));
      end else begin
        want = resp_q.pop_front();
        if (got.version !== want.version || got.length !== want.length ||
            got.command !== want.command || got.feedback !== want.feedback ||
            got.parameter_word !== want.parameter_word) begin
          note_failure($sformatf(
            "response mismatch: exp ver %h len %h cmd %h fb %h par %h, got %h %h %h %h %h",
            want.version, want.length, want.command, want.feedback, want.parameter_word,
            got.version, got.length, got.command, got.feedback, got.parameter_word));
        end
      end
    end
    if (run_left == 0) begin
      run_stall = ($urandom_range(0, 99) < 35);
      if (run_stall) run_left = pause_len() + 1;
      else if ($urandom_range(0, 19) == 0) run_left = 80;
      else run_left = $urandom_range(1, 12);
    end
    run_left--;
    out_stall <= run_stall;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    step_t           plan [$];
    logic [7:0]      frame_q [$];
    logic [7:0]      b;
    logic [15:0]     sum16;
    logic [15:0]     ck;
    drfr_pkg::resp_t r;
    bit              hit;
    bit              en;
    int              pick;
    int              counted;

    // after reset the enable is low: nothing may come out
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_END,   1'b1, 1'b0, '0});
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_START, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_BYTE, 8'h01,                1'b1, 1'b0, '0});
    plan.push_back('{ROW_CFG,  8'h01,                1'b0, 1'b0, '0});
    // close with no frame open: all-zero store checks out
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_END,   1'b1, 1'b1, '0});
    // every field at its maximum, checksum 16'hFA06
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_START, 1'b0, 1'b0, '0});
    repeat (6) plan.push_back('{ROW_BYTE, 8'hFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_BYTE, 8'hFA,                1'b0, 1'b0, '0});
    plan.push_back('{ROW_BYTE, 8'h06,                1'b0, 1'b0, '0});
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_END,   1'b1, 1'b1,
                     '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}});
    // short frame over stale bytes, checksum no longer matches
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_START, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_BYTE, 8'h00,                1'b0, 1'b0, '0});
    plan.push_back('{ROW_BYTE, 8'h80,                1'b0, 1'b0, '0});
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_END,   1'b0, 1'b0, '0});
    // start byte inside a frame restarts it
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_START, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_START, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_BYTE, 8'h33,                1'b0, 1'b0, '0});
    plan.push_back('{ROW_BYTE, drfr_pkg::BYTE_END,   1'b0, 1'b0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        set_enable(plan[i].value[0]);
      end else begin
        send_byte(plan[i].value, hit, r);
        if (plan[i].typed) begin
          if (plan[i].typed_hit) resp_q.push_back(plan[i].typed_resp);
        end else if (hit) begin
          resp_q.push_back(r);
        end
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      en = (phase != 1 && phase != 4);
      set_enable(en);
      counted = 0;
      while (counted < (en ? ACTIVE_BYTES : QUIET_BYTES)) begin
        frame_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          // well-formed frame, a few with a corrupted checksum or overlong tail
          frame_q.push_back(drfr_pkg::BYTE_START);
          sum16 = 16'h0000;
          for (int k = 0; k < 6; k++) begin
            b = free_byte();
            frame_q.push_back(b);
            sum16 = sum16 + {8'h00, b};
          end
          ck = 16'h0000 - sum16;
          if (pick >= 65) ck = ck ^ (16'h0001 << $urandom_range(0, 15));
          frame_q.push_back(ck[15:8]);
          frame_q.push_back(ck[7:0]);
          if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(free_byte());
          end
          frame_q.push_back(drfr_pkg::BYTE_END);
        end else if (pick < 85) begin
          frame_q.push_back(drfr_pkg::BYTE_START);
          repeat ($urandom_range(0, 7)) frame_q.push_back(free_byte());
          frame_q.push_back(drfr_pkg::BYTE_END);
        end else if (pick < 93) begin
          repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          frame_q.push_back($urandom_range(0, 1) ? drfr_pkg::BYTE_END
                                                 : drfr_pkg::BYTE_START);
        end
        foreach (frame_q[k]) begin
          send_byte(frame_q[k], hit, r);
          if (hit) resp_q.push_back(r);
        end
        counted += frame_q.size();
      end
    end

    in_valid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
